/* rtl/asgcd_pkg.sv */
// ----------------------------------------------------------------------------
// asgcd_pkg
// Shared types for the address step gcd accumulator: sequencer states and the
// control/status bundle between the top level and the gcd unit.
// ----------------------------------------------------------------------------
package asgcd_pkg;

  // entry classification carried in tuser
  typedef enum logic [1:0] {
    KIND_FILE  = 2'd0,
    KIND_FUNC  = 2'd1,
    KIND_LINE  = 2'd2,
    KIND_OTHER = 2'd3
  } entry_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GCD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
  } gcd_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } gcd_stat_t;

endpackage

/* rtl/address_step_gcd_accumulator_unit.sv */
// ----------------------------------------------------------------------------
// address_step_gcd_accumulator_unit
// Folds classified debug entries into the running gcd of line address steps.
// ----------------------------------------------------------------------------
// Input stream (s_axis): one request per debug entry. tdata carries the entry
// value, tuser the entry kind and the name-empty flag, tlast marks the last
// entry of a table. Output stream (m_axis): one result per entry, tdata is
// the running step after the entry, tlast echoes the input's tlast.
// Sequencing: one request at a time. An entry that needs no gcd has its
// result shown in the cycle after it is accepted. An entry that combines a
// nonzero difference with a nonzero step runs the iterative gcd unit, one
// halving or one compare-and-subtract per cycle, before the result is shown.
// The next request can be taken in the cycle after the result is taken.
// Reset clears the previous entry, its valid flag and the step. A result with
// tlast clears the same state once it is taken.
// When the receiver stalls, the result holds in its register and s_axis_tready
// stays low.
// ----------------------------------------------------------------------------
module address_step_gcd_accumulator_unit #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // entry_value[31:0]
  input  logic [2:0]  s_axis_tuser,   // entry_kind[1:0], name_empty[2]
  input  logic        s_axis_tlast,   // final_entry
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // step_now[31:0]
  output logic        m_axis_tlast    // table_done
);

  asgcd_pkg::state_t state;
  asgcd_pkg::state_t state_next;

  logic [VALUE_WIDTH-1:0] previous_value;
  logic                   previous_valid;
  logic [VALUE_WIDTH-1:0] running_step;
  logic                   out_last;

  logic                   s_hs;
  logic                   m_hs;
  asgcd_pkg::entry_kind_t kind;
  logic                   name_empty;
  logic [VALUE_WIDTH-1:0] value_w;
  logic [VALUE_WIDTH-1:0] diff;
  logic                   forget;
  logic                   fold;
  logic                   need_gcd;

  asgcd_pkg::gcd_ctl_t    gcd_ctl;
  asgcd_pkg::gcd_stat_t   gcd_stat;
  logic [VALUE_WIDTH-1:0] gcd_result;

  assign s_hs       = s_axis_tvalid && s_axis_tready;
  assign m_hs       = m_axis_tvalid && m_axis_tready;
  assign kind       = asgcd_pkg::entry_kind_t'(s_axis_tuser[1:0]);
  assign name_empty = s_axis_tuser[2];
  assign value_w    = VALUE_WIDTH'(s_axis_tdata);
  assign diff       = value_w - previous_value;

  always_comb begin
    forget   = (kind == asgcd_pkg::KIND_FILE) ||
               ((kind == asgcd_pkg::KIND_FUNC) && !name_empty);
    fold     = (kind == asgcd_pkg::KIND_LINE) ||
               ((kind == asgcd_pkg::KIND_FUNC) && name_empty);
    need_gcd = fold && previous_valid && (running_step != '0) && (diff != '0);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      asgcd_pkg::ST_IDLE: begin
        if (s_hs) begin
          state_next = need_gcd ? asgcd_pkg::ST_GCD : asgcd_pkg::ST_OUT;
        end
      end
      asgcd_pkg::ST_GCD: begin
        if (gcd_stat.done) begin
          state_next = asgcd_pkg::ST_OUT;
        end
      end
      asgcd_pkg::ST_OUT: begin
        if (m_hs) begin
          state_next = asgcd_pkg::ST_IDLE;
        end
      end
      default: state_next = asgcd_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    gcd_ctl.start = 1'b0;
    unique case (state)
      asgcd_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        gcd_ctl.start = s_axis_tvalid && need_gcd;
      end
      asgcd_pkg::ST_GCD: begin
      end
      asgcd_pkg::ST_OUT: begin
        m_axis_tvalid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= asgcd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_value <= '0;
      previous_valid <= 1'b0;
      running_step   <= '0;
    end else begin
      if (s_hs) begin
        out_last <= s_axis_tlast;
        if (forget) begin
          previous_valid <= 1'b0;
        end else if (fold) begin
          // first difference seeds the step, later zero differences are dropped
          if (previous_valid && (running_step == '0)) begin
            running_step <= diff;
          end
          previous_value <= value_w;
          previous_valid <= 1'b1;
        end
      end
      if ((state == asgcd_pkg::ST_GCD) && gcd_stat.done) begin
        running_step <= gcd_result;
      end
      if (m_hs && out_last) begin
        previous_value <= '0;
        previous_valid <= 1'b0;
        running_step   <= '0;
      end
    end
  end

  assign m_axis_tdata = 32'(running_step);
  assign m_axis_tlast = out_last;

  asgcd_gcd_unit #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_gcd (
    .clk    (clk),
    .rst    (rst),
    .ctl    (gcd_ctl),
    .a_in   (running_step),
    .b_in   (diff),
    .stat   (gcd_stat),
    .result (gcd_result)
  );

endmodule

/* rtl/asgcd_gcd_unit.sv */
// ----------------------------------------------------------------------------
// asgcd_gcd_unit
// Iterative binary gcd: one halving or one compare-and-subtract per cycle on
// a shared subtractor, common factors of two counted and restored at the end.
// ----------------------------------------------------------------------------
module asgcd_gcd_unit #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  asgcd_pkg::gcd_ctl_t      ctl,
  input  logic [VALUE_WIDTH-1:0]   a_in,
  input  logic [VALUE_WIDTH-1:0]   b_in,
  output asgcd_pkg::gcd_stat_t     stat,
  output logic [VALUE_WIDTH-1:0]   result
);

  localparam int KW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

  logic [VALUE_WIDTH-1:0] a;
  logic [VALUE_WIDTH-1:0] b;
  logic [KW-1:0]          k;
  logic                   busy;
  logic                   done;

  logic                   a_gt_b;
  logic [VALUE_WIDTH-1:0] hi;
  logic [VALUE_WIDTH-1:0] lo;
  logic [VALUE_WIDTH-1:0] sub;

  // shared compare and subtract
  always_comb begin
    a_gt_b = a > b;
    hi     = a_gt_b ? a : b;
    lo     = a_gt_b ? b : a;
    sub    = hi - lo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
      end else if (busy && a[0] && b[0] && (a == b)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a <= a_in;
      b <= b_in;
      k <= '0;
    end else if (busy) begin
      priority if (!a[0] && !b[0]) begin
        // common factor of two
        a <= a >> 1;
        b <= b >> 1;
        k <= k + KW'(1);
      end else if (!a[0]) begin
        a <= a >> 1;
      end else if (!b[0]) begin
        b <= b >> 1;
      end else if (a != b) begin
        a <= lo;
        b <= sub;
      end
    end
  end

  assign result    = a << k;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

/* rtl/asgcd_checker.sv */
// ----------------------------------------------------------------------------
// asgcd_checker
// Port-level checks of the accumulator's request/result sequencing.
// ----------------------------------------------------------------------------
module asgcd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // one request in flight: accepting blocks further requests
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second request taken while busy");

  // no request taken while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("ready while result pending");

  // taking the result frees the input side
  a_ready_after_out: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready |=> s_axis_tready && !m_axis_tvalid)
    else $error("not ready after result taken");

  // a closed table starts again from a zero step
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && m_axis_tlast ##1
      s_axis_tvalid && s_axis_tready ##1 m_axis_tvalid |->
      (m_axis_tdata == 32'd0))
    else $error("step not cleared after last entry");

endmodule

bind address_step_gcd_accumulator_unit asgcd_checker u_asgcd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
